[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line intersection unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define PLI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define PLI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/pli_pkg.sv]
// ---------------------------------------------------------------------------
// Paired line intersection package
// Widths, codes, command and status types, and the multiply sequence table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

	localparam int COORD_WIDTH = 24;
	// Point differences and multiplier operands.
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int OPND_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * OPND_W;
	// Denominator, point cross terms and numerators.
	localparam int D_W = 2 * COORD_WIDTH + 3;
	localparam int A_W = 2 * COORD_WIDTH + 1;
	localparam int N_W = 3 * COORD_WIDTH + 1;
	localparam int ACC_W = 3 * COORD_WIDTH + 3;
	localparam int CNT_W = $clog2(COORD_WIDTH);

	localparam int NUM_STEPS = 14;
	localparam int STEP_W = $clog2(NUM_STEPS);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef enum logic [3:0] {
		MS_DX12_DY34,
		MS_DY12_DX34,
		MS_X1_Y2,
		MS_Y1_X2,
		MS_X3_Y4,
		MS_Y3_X4,
		MS_ALO_DX34,
		MS_AHI_DX34,
		MS_DX12_BLO,
		MS_DX12_BHI,
		MS_ALO_DY34,
		MS_AHI_DY34,
		MS_DY12_BLO,
		MS_DY12_BHI
	} mul_sel_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_D,
		DST_A,
		DST_B,
		DST_NX,
		DST_NY
	} acc_dst_t;

	typedef struct packed {
		mul_sel_t sel;
		logic     first;
		logic     sub;
		logic     hi;
		acc_dst_t dst;
	} mop_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_DRAIN,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} ctrl_state_t;

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_SETUP,
		DV_ITER,
		DV_FIX,
		DV_DONE
	} div_state_t;

	typedef struct packed {
		logic              ld_held;
		logic              ld_new;
		logic              prep;
		logic              mul_en;
		logic [STEP_W-1:0] step;
		logic              div_start;
		logic              out_load;
		logic              out_degen;
	} dp_cmd_t;

	typedef struct packed {
		logic d_zero;
		logic div_done;
	} dp_stat_t;

	// One multiply per step. Wide terms are split at COORD_WIDTH into a low
	// unsigned part and a high signed part that is weighted by 2^COORD_WIDTH.
	function automatic mop_t mop_of(input logic [STEP_W-1:0] step);
		mop_t m;
		m = '{sel: MS_DX12_DY34, first: 1'b1, sub: 1'b0, hi: 1'b0, dst: DST_NONE};
		case (step)
			4'd0:  m = '{MS_DX12_DY34, 1'b1, 1'b0, 1'b0, DST_NONE};
			4'd1:  m = '{MS_DY12_DX34, 1'b0, 1'b1, 1'b0, DST_D};
			4'd2:  m = '{MS_X1_Y2,     1'b1, 1'b0, 1'b0, DST_NONE};
			4'd3:  m = '{MS_Y1_X2,     1'b0, 1'b1, 1'b0, DST_A};
			4'd4:  m = '{MS_X3_Y4,     1'b1, 1'b0, 1'b0, DST_NONE};
			4'd5:  m = '{MS_Y3_X4,     1'b0, 1'b1, 1'b0, DST_B};
			4'd6:  m = '{MS_ALO_DX34,  1'b1, 1'b0, 1'b0, DST_NONE};
			4'd7:  m = '{MS_AHI_DX34,  1'b0, 1'b0, 1'b1, DST_NONE};
			4'd8:  m = '{MS_DX12_BLO,  1'b0, 1'b1, 1'b0, DST_NONE};
			4'd9:  m = '{MS_DX12_BHI,  1'b0, 1'b1, 1'b1, DST_NX};
			4'd10: m = '{MS_ALO_DY34,  1'b1, 1'b0, 1'b0, DST_NONE};
			4'd11: m = '{MS_AHI_DY34,  1'b0, 1'b0, 1'b1, DST_NONE};
			4'd12: m = '{MS_DY12_BLO,  1'b0, 1'b1, 1'b0, DST_NONE};
			4'd13: m = '{MS_DY12_BHI,  1'b0, 1'b1, 1'b1, DST_NY};
			default: m = '{MS_DX12_DY34, 1'b1, 1'b0, 1'b0, DST_NONE};
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[rtl/core/pli_div.sv]
// ---------------------------------------------------------------------------
// Saturating divider
// Restoring division, one quotient bit per cycle, truncating toward zero and
// clamping the quotient to the signed coordinate range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [pli_pkg::N_W-1:0]        num,
	input  wire logic signed [pli_pkg::D_W-1:0]        den,
	output logic                                       done,
	output logic                                       sat,
	output logic signed [pli_pkg::COORD_WIDTH-1:0]     quo
);

	`include "assert_macros.svh"

	pli_pkg::div_state_t state_q, state_d;

	logic [pli_pkg::N_W-1:0]         nmag_q;
	logic [pli_pkg::D_W-1:0]         dmag_q;
	logic                            neg_q;
	logic                            ovf_q;
	logic [pli_pkg::D_W-1:0]         rem_q;
	logic [pli_pkg::COORD_WIDTH-1:0] lo_q;
	logic [pli_pkg::CNT_W-1:0]       cnt_q;
	logic                            sat_q;
	logic [pli_pkg::COORD_WIDTH-1:0] quo_q;

	logic [pli_pkg::N_W-1:0]         nmag_c;
	logic [pli_pkg::D_W-1:0]         dmag_c;
	logic [pli_pkg::D_W-1:0]         num_hi;
	logic [pli_pkg::D_W:0]           trial;
	logic [pli_pkg::D_W:0]           diff;
	logic                            ge;
	logic [pli_pkg::COORD_WIDTH-1:0] lim;
	logic                            clamp;
	logic [pli_pkg::COORD_WIDTH-1:0] mag;
	logic                            last;

	assign nmag_c = num[pli_pkg::N_W-1] ? pli_pkg::N_W'(-num) : pli_pkg::N_W'(num);
	assign dmag_c = den[pli_pkg::D_W-1] ? pli_pkg::D_W'(-den) : pli_pkg::D_W'(den);

	// The upper part of the numerator seeds the remainder; if it already
	// reaches the divisor, the quotient cannot fit the coordinate range.
	assign num_hi = pli_pkg::D_W'(nmag_q[pli_pkg::N_W-1:pli_pkg::COORD_WIDTH]);

	assign trial = {rem_q, lo_q[pli_pkg::COORD_WIDTH-1]};
	assign diff  = trial - {1'b0, dmag_q};
	assign ge    = (trial >= {1'b0, dmag_q});
	assign last  = (cnt_q == pli_pkg::CNT_W'(pli_pkg::COORD_WIDTH - 1));

	assign lim   = {1'b0, {(pli_pkg::COORD_WIDTH-1){1'b1}}} + pli_pkg::COORD_WIDTH'(neg_q);
	assign clamp = ovf_q || (lo_q > lim);
	assign mag   = clamp ? lim : lo_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pli_pkg::DV_IDLE:  state_d = pli_pkg::DV_IDLE;
			pli_pkg::DV_SETUP: state_d = pli_pkg::DV_ITER;
			pli_pkg::DV_ITER:  state_d = last ? pli_pkg::DV_FIX : pli_pkg::DV_ITER;
			pli_pkg::DV_FIX:   state_d = pli_pkg::DV_DONE;
			pli_pkg::DV_DONE:  state_d = pli_pkg::DV_DONE;
			default:           state_d = pli_pkg::DV_IDLE;
		endcase
		if (start) begin
			state_d = pli_pkg::DV_SETUP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pli_pkg::DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nmag_q <= nmag_c;
			dmag_q <= dmag_c;
			neg_q  <= num[pli_pkg::N_W-1] ^ den[pli_pkg::D_W-1];
		end
		case (state_q)
			pli_pkg::DV_SETUP: begin
				ovf_q <= (num_hi >= dmag_q);
				rem_q <= num_hi;
				lo_q  <= nmag_q[pli_pkg::COORD_WIDTH-1:0];
				cnt_q <= '0;
			end
			pli_pkg::DV_ITER: begin
				// The numerator bits shift out of lo_q as quotient bits shift in.
				rem_q <= ge ? diff[pli_pkg::D_W-1:0] : trial[pli_pkg::D_W-1:0];
				lo_q  <= {lo_q[pli_pkg::COORD_WIDTH-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			pli_pkg::DV_FIX: begin
				sat_q <= clamp;
				quo_q <= neg_q ? -mag : mag;
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == pli_pkg::DV_DONE);
	assign sat  = sat_q;
	assign quo  = $signed(quo_q);

	`PLI_ASSERT_NEXT(a_start_setup, clk, arst_n, start, state_q == pli_pkg::DV_SETUP)
	`PLI_ASSERT_IMPLY(a_rem_below_div, clk, arst_n, state_q == pli_pkg::DV_ITER && !ovf_q, rem_q < dmag_q)
	`PLI_ASSERT_IMPLY(a_quo_sign, clk, arst_n, state_q == pli_pkg::DV_DONE && quo_q != '0, quo_q[pli_pkg::COORD_WIDTH-1] == neg_q)

endmodule

`default_nettype wire

[rtl/core/pli_dpath.sv]
// ---------------------------------------------------------------------------
// Line intersection datapath
// Point registers, one shared signed multiplier with an accumulator, the
// cross-product terms, two dividers and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_dpath (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire pli_pkg::dp_cmd_t                        cmd,
	output pli_pkg::dp_stat_t                            stat,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  x_first,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  y_first,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  x_second,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  y_second,
	output logic signed [pli_pkg::COORD_WIDTH-1:0]       x_cross,
	output logic signed [pli_pkg::COORD_WIDTH-1:0]       y_cross,
	output logic [1:0]                                   status
);

	logic signed [pli_pkg::COORD_WIDTH-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [pli_pkg::COORD_WIDTH-1:0] x3_q, y3_q, x4_q, y4_q;
	logic signed [pli_pkg::DIFF_W-1:0]      dx12_q, dy12_q, dx34_q, dy34_q;
	logic signed [pli_pkg::D_W-1:0]         d_q;
	logic signed [pli_pkg::A_W-1:0]         a_q, b_q;
	logic signed [pli_pkg::N_W-1:0]         nx_q, ny_q;
	logic signed [pli_pkg::ACC_W-1:0]       acc_q;

	logic signed [pli_pkg::PROD_W-1:0]      prod_s1;
	pli_pkg::mop_t                          mop_s1;
	logic                                   mul_v_s1;

	pli_pkg::mop_t                          mop;
	logic signed [pli_pkg::OPND_W-1:0]      opa, opb;
	logic signed [pli_pkg::OPND_W-1:0]      alo, ahi, blo, bhi;
	logic signed [pli_pkg::PROD_W-1:0]      prod;
	logic signed [pli_pkg::ACC_W-1:0]       term, shifted, base, acc_nx;

	logic                                   dx_done, dy_done, sx, sy;
	logic signed [pli_pkg::COORD_WIDTH-1:0] qx, qy;

	logic signed [pli_pkg::COORD_WIDTH-1:0] x_cross_q, y_cross_q;
	logic [1:0]                             status_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_held) begin
			x1_q <= x_first;
			y1_q <= y_first;
			x2_q <= x_second;
			y2_q <= y_second;
		end
		if (cmd.ld_new) begin
			x3_q <= x_first;
			y3_q <= y_first;
			x4_q <= x_second;
			y4_q <= y_second;
		end
		if (cmd.prep) begin
			dx12_q <= pli_pkg::DIFF_W'(x1_q) - pli_pkg::DIFF_W'(x2_q);
			dy12_q <= pli_pkg::DIFF_W'(y1_q) - pli_pkg::DIFF_W'(y2_q);
			dx34_q <= pli_pkg::DIFF_W'(x3_q) - pli_pkg::DIFF_W'(x4_q);
			dy34_q <= pli_pkg::DIFF_W'(y3_q) - pli_pkg::DIFF_W'(y4_q);
		end
	end

	assign alo = $signed({1'b0, a_q[pli_pkg::COORD_WIDTH-1:0]});
	assign ahi = $signed(a_q[pli_pkg::A_W-1:pli_pkg::COORD_WIDTH]);
	assign blo = $signed({1'b0, b_q[pli_pkg::COORD_WIDTH-1:0]});
	assign bhi = $signed(b_q[pli_pkg::A_W-1:pli_pkg::COORD_WIDTH]);

	always_comb begin
		mop = pli_pkg::mop_of(cmd.step);
		opa = dx12_q;
		opb = dy34_q;
		case (mop.sel)
			pli_pkg::MS_DX12_DY34: begin opa = dx12_q; opb = dy34_q; end
			pli_pkg::MS_DY12_DX34: begin opa = dy12_q; opb = dx34_q; end
			pli_pkg::MS_X1_Y2: begin
				opa = pli_pkg::OPND_W'(x1_q);
				opb = pli_pkg::OPND_W'(y2_q);
			end
			pli_pkg::MS_Y1_X2: begin
				opa = pli_pkg::OPND_W'(y1_q);
				opb = pli_pkg::OPND_W'(x2_q);
			end
			pli_pkg::MS_X3_Y4: begin
				opa = pli_pkg::OPND_W'(x3_q);
				opb = pli_pkg::OPND_W'(y4_q);
			end
			pli_pkg::MS_Y3_X4: begin
				opa = pli_pkg::OPND_W'(y3_q);
				opb = pli_pkg::OPND_W'(x4_q);
			end
			pli_pkg::MS_ALO_DX34:  begin opa = alo; opb = dx34_q; end
			pli_pkg::MS_AHI_DX34:  begin opa = ahi; opb = dx34_q; end
			pli_pkg::MS_DX12_BLO:  begin opa = dx12_q; opb = blo; end
			pli_pkg::MS_DX12_BHI:  begin opa = dx12_q; opb = bhi; end
			pli_pkg::MS_ALO_DY34:  begin opa = alo; opb = dy34_q; end
			pli_pkg::MS_AHI_DY34:  begin opa = ahi; opb = dy34_q; end
			pli_pkg::MS_DY12_BLO:  begin opa = dy12_q; opb = blo; end
			pli_pkg::MS_DY12_BHI:  begin opa = dy12_q; opb = bhi; end
			default:               begin opa = dx12_q; opb = dy34_q; end
		endcase
	end

	assign prod = opa * opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1 <= 1'b0;
		end else begin
			mul_v_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		mop_s1  <= mop;
	end

	// Accumulate stage: a high partial product carries weight 2^COORD_WIDTH.
	assign term    = pli_pkg::ACC_W'(prod_s1);
	assign shifted = mop_s1.hi ? (term <<< pli_pkg::COORD_WIDTH) : term;
	assign base    = mop_s1.first ? '0 : acc_q;
	assign acc_nx  = mop_s1.sub ? (base - shifted) : (base + shifted);

	always_ff @(posedge clk) begin
		if (mul_v_s1) begin
			acc_q <= acc_nx;
			case (mop_s1.dst)
				pli_pkg::DST_D:  d_q  <= acc_nx[pli_pkg::D_W-1:0];
				pli_pkg::DST_A:  a_q  <= acc_nx[pli_pkg::A_W-1:0];
				pli_pkg::DST_B:  b_q  <= acc_nx[pli_pkg::A_W-1:0];
				pli_pkg::DST_NX: nx_q <= acc_nx[pli_pkg::N_W-1:0];
				pli_pkg::DST_NY: ny_q <= acc_nx[pli_pkg::N_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pli_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (nx_q),
		.den    (d_q),
		.done   (dx_done),
		.sat    (sx),
		.quo    (qx)
	);

	pli_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (ny_q),
		.den    (d_q),
		.done   (dy_done),
		.sat    (sy),
		.quo    (qy)
	);

	assign stat.d_zero   = (d_q == '0);
	assign stat.div_done = dx_done && dy_done;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_degen) begin
				x_cross_q <= '0;
				y_cross_q <= '0;
				status_q  <= pli_pkg::ST_DEGEN;
			end else begin
				x_cross_q <= qx;
				y_cross_q <= qy;
				status_q  <= (sx || sy) ? pli_pkg::ST_SAT : pli_pkg::ST_OK;
			end
		end
	end

	assign x_cross = x_cross_q;
	assign y_cross = y_cross_q;
	assign status  = status_q;

endmodule

`default_nettype wire

[rtl/core/pli_ctrl.sv]
// ---------------------------------------------------------------------------
// Line intersection controller
// Pairs events, steps the multiply sequence, starts the dividers and hands
// the finished result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              evt_valid,
	output logic                   evt_ready,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output pli_pkg::dp_cmd_t       cmd,
	input  wire pli_pkg::dp_stat_t stat
);

	`include "assert_macros.svh"

	pli_pkg::ctrl_state_t         state_q, state_d;
	logic                         phase_q, phase_d;
	logic [pli_pkg::STEP_W-1:0]   step_q, step_d;
	logic                         degen_q, degen_d;
	logic                         res_valid_q, res_valid_d;
	logic                         last_step;

	assign last_step = (step_q == pli_pkg::STEP_W'(pli_pkg::NUM_STEPS - 1));

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		step_d    = step_q;
		degen_d   = degen_q;
		cmd       = '0;
		evt_ready = 1'b0;
		case (state_q)
			pli_pkg::S_IDLE: begin
				evt_ready = 1'b1;
				if (evt_valid) begin
					if (!phase_q) begin
						cmd.ld_held = 1'b1;
						phase_d     = 1'b1;
					end else begin
						cmd.ld_new = 1'b1;
						phase_d    = 1'b0;
						state_d    = pli_pkg::S_PREP;
					end
				end
			end
			pli_pkg::S_PREP: begin
				cmd.prep = 1'b1;
				step_d   = '0;
				state_d  = pli_pkg::S_MUL;
			end
			pli_pkg::S_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.step   = step_q;
				if (last_step) begin
					state_d = pli_pkg::S_DRAIN;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			pli_pkg::S_DRAIN: begin
				// The last numerator lands here; the denominator settled earlier.
				degen_d = stat.d_zero;
				state_d = stat.d_zero ? pli_pkg::S_FINISH : pli_pkg::S_DIV_GO;
			end
			pli_pkg::S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = pli_pkg::S_DIV_WAIT;
			end
			pli_pkg::S_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = pli_pkg::S_FINISH;
				end
			end
			pli_pkg::S_FINISH: begin
				if (!res_valid_q || res_ready) begin
					cmd.out_load  = 1'b1;
					cmd.out_degen = degen_q;
					state_d       = pli_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pli_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		res_valid_d = res_valid_q;
		if (cmd.out_load) begin
			res_valid_d = 1'b1;
		end else if (res_ready) begin
			res_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pli_pkg::S_IDLE;
			phase_q     <= 1'b0;
			step_q      <= '0;
			degen_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			step_q      <= step_d;
			degen_q     <= degen_d;
			res_valid_q <= res_valid_d;
		end
	end

	assign res_valid = res_valid_q;

	`PLI_ASSERT_NEXT(a_pair_start, clk, arst_n, evt_valid && evt_ready && phase_q, state_q == pli_pkg::S_PREP && !phase_q)
	`PLI_ASSERT_NEXT(a_seq_end, clk, arst_n, state_q == pli_pkg::S_MUL && last_step, state_q == pli_pkg::S_DRAIN)
	`PLI_ASSERT_IMPLY(a_busy_phase, clk, arst_n, state_q != pli_pkg::S_IDLE, !phase_q)
	`PLI_ASSERT_NEXT(a_div_finish, clk, arst_n, state_q == pli_pkg::S_DIV_WAIT && stat.div_done, state_q == pli_pkg::S_FINISH)

endmodule

`default_nettype wire

[rtl/core/paired_line_intersection_unit.sv]
// ---------------------------------------------------------------------------
// Paired line intersection unit
// Takes two-point events in pairs and returns the crossing point of the two
// lines, with flags for parallel lines and saturated coordinates.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  event    evt_valid/evt_ready    x_first, y_first, x_second, y_second
//  result   res_valid/res_ready    x_cross, y_cross, status
//
//  The first event of a pair is taken while the unit is idle and yields no result.
//  The second event's result becomes valid when the next request can also be
//  taken: fourteen steps on the shared 25x25 multiplier, then the two
//  restoring dividers, one quotient bit per cycle, run side by side.
//  A parallel or degenerate pair skips the dividers and finishes early.
//  A finished result waits in the output register while new requests are
//  taken; the unit stalls before loading the next result until it is free.
//  Reset is asynchronous and clears the pairing phase and all control state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module paired_line_intersection_unit (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    evt_valid,
	output logic                                         evt_ready,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  x_first,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  y_first,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  x_second,
	input  wire logic signed [pli_pkg::COORD_WIDTH-1:0]  y_second,
	output logic                                         res_valid,
	input  wire logic                                    res_ready,
	output logic signed [pli_pkg::COORD_WIDTH-1:0]       x_cross,
	output logic signed [pli_pkg::COORD_WIDTH-1:0]       y_cross,
	output logic [1:0]                                   status
);

	pli_pkg::dp_cmd_t  cmd;
	pli_pkg::dp_stat_t stat;

	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pli_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.x_first  (x_first),
		.y_first  (y_first),
		.x_second (x_second),
		.y_second (y_second),
		.x_cross  (x_cross),
		.y_cross  (y_cross),
		.status   (status)
	);

endmodule

`default_nettype wire
